// File: src/pidc_pkg.sv
// Package for the PI PWM duty controller: sizes, fixed-point constants,
// register indexes and the control-word and capture types.
// No dependencies.
package pidc_pkg;

   localparam int WAVE_LENGTH    = 1000;
   localparam int CAPTURE_POINTS = 200;
   localparam int DECIMATE_BY    = 10;

   localparam int HALF_WAVE   = WAVE_LENGTH / 2;
   localparam int PHASE_W     = 10;
   localparam int DEC_W       = 4;
   localparam int POINT_W     = 8;

   localparam int SAMPLE_W    = 10;
   localparam int GAIN_W      = 16;
   localparam int INTEG_W     = 24;
   localparam int PERIOD_W    = 16;
   localparam int DUTY_W      = 16;
   localparam int ERR_W       = SAMPLE_W + 1;
   localparam int ACC_W       = 42;
   localparam int PCT_W       = 15;
   localparam int MUL_A_W     = 25;
   localparam int MUL_B_W     = 23;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int QUOT_IN_W   = 21;
   localparam int RECIP_W     = 22;
   localparam int RECIP_SHIFT = 26;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;

   // percent in Q.8: 50 % offset and 100 % full scale
   localparam logic [PCT_W-1:0] PCT_OFFSET = PCT_W'(12800);
   localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(25600);
   // floor(2^26 / 25); duty = floor(floor(pct * period / 1024) / 25)
   localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'((2 ** RECIP_SHIFT) / 25);
   localparam logic [QUOT_IN_W-1:0] DIVISOR_25 = QUOT_IN_W'(25);

   localparam logic [SAMPLE_W-1:0] REF_HIGH_RST   = SAMPLE_W'(800);
   localparam logic [SAMPLE_W-1:0] REF_LOW_RST    = SAMPLE_W'(200);
   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = PERIOD_W'(2399);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP           = 3'd0,
      CSR_KI           = 3'd1,
      CSR_INTEGRAL_MAX = 3'd2,
      CSR_REF_HIGH     = 3'd3,
      CSR_REF_LOW      = 3'd4,
      CSR_PWM_PERIOD   = 3'd5
   } csr_index_type;

   localparam int STEP_W = 4;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_KP_E,
      MUL_KI_I,
      MUL_PCT_PER,
      MUL_Y_RECIP
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      Q_NONE,
      Q_LOAD,
      Q_INC
   } q_op_type;

   typedef enum logic [0:0] {
      JMP_NONE,
      JMP_REM_LOW
   } jump_cond_type;

   typedef struct packed {
      mul_sel_type        mul_sel;
      acc_op_type         acc_op;
      logic               integ_we;
      logic               pct_we;
      logic               y_we;
      q_op_type           q_op;
      jump_cond_type      jump_cond;
      logic [STEP_W-1:0]  jump_target;
      logic               finish;
   } ctrl_word_type;

   typedef struct packed {
      logic rem_low;
   } dp_status_type;

   typedef struct packed {
      logic                valid;
      logic [POINT_W-1:0]  index;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] reference;
      logic                last;
   } capture_type;

endpackage

// File: src/pidc_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on pidc_pkg.
interface pidc_req_if;
   logic                          valid;
   logic                          ready;
   logic [pidc_pkg::SAMPLE_W-1:0] adc_sample;
   logic                          start_capture;

   modport source (output valid, output adc_sample, output start_capture, input ready);
   modport sink   (input valid, input adc_sample, input start_capture, output ready);
endinterface

interface pidc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pidc_pkg::DUTY_W-1:0]   duty;
   logic                          capture_valid;
   logic [pidc_pkg::POINT_W-1:0]  capture_index;
   logic [pidc_pkg::SAMPLE_W-1:0] captured_sample;
   logic [pidc_pkg::SAMPLE_W-1:0] captured_reference;
   logic                          capture_last;

   modport source (output valid, output duty, output capture_valid, output capture_index,
                   output captured_sample, output captured_reference,
                   output capture_last, input ready);
   modport sink   (input valid, input duty, input capture_valid, input capture_index,
                   input captured_sample, input captured_reference,
                   input capture_last, output ready);
endinterface

interface pidc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pidc_pkg::CSR_IDX_W-1:0]  index;
   logic [pidc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/pidc_sequencer.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on pidc_pkg.
module pidc_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    out_free,
   input  pidc_pkg::dp_status_type status,
   output pidc_pkg::ctrl_word_type cw,
   output logic                    busy,
   output logic                    tick
);

   logic                        busy_ff;
   logic [pidc_pkg::STEP_W-1:0] step_ff;
   pidc_pkg::ctrl_word_type     rom_word;
   logic                        jump_taken;

   function automatic pidc_pkg::ctrl_word_type ucode_rom(input logic [pidc_pkg::STEP_W-1:0] s);
      pidc_pkg::ctrl_word_type w;
      w = '{mul_sel: pidc_pkg::MUL_NONE, acc_op: pidc_pkg::ACC_NONE, integ_we: 1'b0,
            pct_we: 1'b0, y_we: 1'b0, q_op: pidc_pkg::Q_NONE,
            jump_cond: pidc_pkg::JMP_NONE, jump_target: '0, finish: 1'b0};
      case (s)
         4'd0: w.mul_sel = pidc_pkg::MUL_KP_E;
         4'd1: begin
            w.acc_op  = pidc_pkg::ACC_LOAD;
            w.mul_sel = pidc_pkg::MUL_KI_I;
         end
         4'd2: begin
            w.acc_op   = pidc_pkg::ACC_ADD;
            w.integ_we = 1'b1;
         end
         4'd3: w.pct_we = 1'b1;
         4'd4: w.mul_sel = pidc_pkg::MUL_PCT_PER;
         4'd5: begin
            w.mul_sel = pidc_pkg::MUL_Y_RECIP;
            w.y_we    = 1'b1;
         end
         4'd6: w.q_op = pidc_pkg::Q_LOAD;
         4'd7: begin
            w.jump_cond   = pidc_pkg::JMP_REM_LOW;
            w.jump_target = 4'd9;
         end
         4'd8: w.q_op = pidc_pkg::Q_INC;
         default: w.finish = 1'b1;
      endcase
      return w;
   endfunction

   always_comb begin
      rom_word = ucode_rom(step_ff);
      cw       = rom_word;
      if (!busy_ff) begin
         cw = '{mul_sel: pidc_pkg::MUL_NONE, acc_op: pidc_pkg::ACC_NONE, integ_we: 1'b0,
                pct_we: 1'b0, y_we: 1'b0, q_op: pidc_pkg::Q_NONE,
                jump_cond: pidc_pkg::JMP_NONE, jump_target: '0, finish: 1'b0};
      end
   end

   always_comb begin
      case (rom_word.jump_cond)
         pidc_pkg::JMP_REM_LOW: jump_taken = status.rem_low;
         default:               jump_taken = 1'b0;
      endcase
   end

   assign busy = busy_ff;
   assign tick = busy_ff && rom_word.finish && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (rom_word.finish) begin
            if (out_free) begin
               busy_ff <= 1'b0;
            end
         end else if (jump_taken) begin
            step_ff <= rom_word.jump_target;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

endmodule

// File: src/pidc_datapath.sv
// Arithmetic datapath: shared multiplier, accumulator, integral clamp,
// percent clamp and reciprocal divide by 25600. Depends on pidc_pkg.
module pidc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  pidc_pkg::ctrl_word_type              cw,
   input  logic [pidc_pkg::SAMPLE_W-1:0]        adc_sample,
   input  logic [pidc_pkg::SAMPLE_W-1:0]        ref_level,
   input  logic signed [pidc_pkg::GAIN_W-1:0]   kp,
   input  logic signed [pidc_pkg::GAIN_W-1:0]   ki,
   input  logic signed [pidc_pkg::INTEG_W-1:0]  integral_max,
   input  logic [pidc_pkg::PERIOD_W-1:0]        pwm_period,
   output pidc_pkg::dp_status_type              status,
   output logic [pidc_pkg::DUTY_W-1:0]          duty
);

   localparam logic signed [pidc_pkg::INTEG_W:0] INTEG_MIN =
      -(pidc_pkg::INTEG_W+1)'(2 ** (pidc_pkg::INTEG_W - 1));

   logic signed [pidc_pkg::ERR_W-1:0]     err_ff;
   logic signed [pidc_pkg::INTEG_W-1:0]   integ_ff;
   logic signed [pidc_pkg::ACC_W-1:0]     acc_ff;
   logic signed [pidc_pkg::PROD_W-1:0]    prod_ff;
   logic [pidc_pkg::PCT_W-1:0]            pct_ff;
   logic [pidc_pkg::QUOT_IN_W-1:0]        y_ff;
   logic [pidc_pkg::DUTY_W-1:0]           q_ff;

   logic signed [pidc_pkg::MUL_A_W-1:0]   mul_a;
   logic signed [pidc_pkg::MUL_B_W-1:0]   mul_b;
   logic signed [pidc_pkg::PROD_W-1:0]    prod_in;
   logic signed [pidc_pkg::INTEG_W:0]     integ_sum;
   logic signed [pidc_pkg::INTEG_W:0]     integ_clamped;
   logic [pidc_pkg::PCT_W-1:0]            pct_in;
   logic [pidc_pkg::QUOT_IN_W-1:0]        rem;

   always_comb begin
      case (cw.mul_sel)
         pidc_pkg::MUL_KP_E: begin
            mul_a = pidc_pkg::MUL_A_W'(err_ff);
            mul_b = pidc_pkg::MUL_B_W'(kp);
         end
         pidc_pkg::MUL_KI_I: begin
            mul_a = pidc_pkg::MUL_A_W'(integ_ff);
            mul_b = pidc_pkg::MUL_B_W'(ki);
         end
         pidc_pkg::MUL_PCT_PER: begin
            mul_a = $signed({{(pidc_pkg::MUL_A_W-pidc_pkg::PERIOD_W){1'b0}}, pwm_period});
            mul_b = $signed({{(pidc_pkg::MUL_B_W-pidc_pkg::PCT_W){1'b0}}, pct_ff});
         end
         pidc_pkg::MUL_Y_RECIP: begin
            mul_a = $signed({{(pidc_pkg::MUL_A_W-pidc_pkg::QUOT_IN_W){1'b0}},
                             prod_ff[pidc_pkg::QUOT_IN_W+9:10]});
            mul_b = $signed({{(pidc_pkg::MUL_B_W-pidc_pkg::RECIP_W){1'b0}},
                             pidc_pkg::RECIP_25});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      integ_sum     = (pidc_pkg::INTEG_W+1)'(integ_ff) + (pidc_pkg::INTEG_W+1)'(err_ff);
      integ_clamped = integ_sum;
      if (integ_clamped > (pidc_pkg::INTEG_W+1)'(integral_max)) begin
         integ_clamped = (pidc_pkg::INTEG_W+1)'(integral_max);
      end
      if (integ_clamped < INTEG_MIN) begin
         integ_clamped = INTEG_MIN;
      end
   end

   always_comb begin
      if (acc_ff[pidc_pkg::ACC_W-1]) begin
         pct_in = '0;
      end else if (acc_ff > $signed({{(pidc_pkg::ACC_W-pidc_pkg::PCT_W){1'b0}},
                                     pidc_pkg::PCT_FULL})) begin
         pct_in = pidc_pkg::PCT_FULL;
      end else begin
         pct_in = acc_ff[pidc_pkg::PCT_W-1:0];
      end
   end

   // quotient estimate is low by at most one
   assign rem = y_ff - ({5'd0, q_ff} * pidc_pkg::DIVISOR_25);
   assign status.rem_low = rem < pidc_pkg::DIVISOR_25;
   assign duty = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (cw.integ_we) begin
         integ_ff <= integ_clamped[pidc_pkg::INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= $signed({1'b0, ref_level}) - $signed({1'b0, adc_sample});
      end
      if (cw.mul_sel != pidc_pkg::MUL_NONE) begin
         prod_ff <= prod_in;
      end
      case (cw.acc_op)
         pidc_pkg::ACC_LOAD: acc_ff <= prod_ff[pidc_pkg::ACC_W-1:0];
         pidc_pkg::ACC_ADD:  acc_ff <= acc_ff + prod_ff[pidc_pkg::ACC_W-1:0]
                                       + $signed({{(pidc_pkg::ACC_W-pidc_pkg::PCT_W){1'b0}},
                                                  pidc_pkg::PCT_OFFSET});
         default: ;
      endcase
      if (cw.pct_we) begin
         pct_ff <= pct_in;
      end
      if (cw.y_we) begin
         y_ff <= prod_ff[pidc_pkg::QUOT_IN_W+9:10];
      end
      case (cw.q_op)
         pidc_pkg::Q_LOAD: q_ff <= prod_ff[pidc_pkg::RECIP_SHIFT+pidc_pkg::DUTY_W-1:
                                           pidc_pkg::RECIP_SHIFT];
         pidc_pkg::Q_INC:  q_ff <= q_ff + 1'b1;
         default: ;
      endcase
   end

endmodule

// File: src/pidc_capture.sv
// Wave phase counter and decimated capture run state, advanced once per
// finished request. Depends on pidc_pkg.
module pidc_capture (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick,
   input  logic                          start,
   input  logic [pidc_pkg::SAMPLE_W-1:0] adc_sample,
   input  logic [pidc_pkg::SAMPLE_W-1:0] ref_level,
   output logic                          first_half,
   output pidc_pkg::capture_type         capture
);

   logic [pidc_pkg::PHASE_W-1:0] phase_ff;
   logic [pidc_pkg::DEC_W-1:0]   dec_ff;
   logic [pidc_pkg::POINT_W-1:0] point_ff;
   logic                         capturing_ff;

   logic [pidc_pkg::PHASE_W:0]   phase_next;
   logic [pidc_pkg::DEC_W-1:0]   dec_next;
   logic [pidc_pkg::POINT_W:0]   point_next;
   logic                         active;
   logic                         record;
   logic                         run_end;

   assign first_half = {1'b0, phase_ff} < (pidc_pkg::PHASE_W+1)'(pidc_pkg::HALF_WAVE);
   assign phase_next = {1'b0, phase_ff} + 1'b1;
   assign active     = capturing_ff || start;
   assign dec_next   = dec_ff + 1'b1;
   assign record     = active && (dec_next >= pidc_pkg::DEC_W'(pidc_pkg::DECIMATE_BY));
   assign point_next = {1'b0, point_ff} + 1'b1;
   assign run_end    = record &&
                       (point_next >= (pidc_pkg::POINT_W+1)'(pidc_pkg::CAPTURE_POINTS));

   always_comb begin
      capture.valid     = record;
      capture.index     = record ? point_ff : '0;
      capture.sample    = record ? adc_sample : '0;
      capture.reference = record ? ref_level : '0;
      capture.last      = run_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         dec_ff       <= '0;
         point_ff     <= '0;
         capturing_ff <= 1'b0;
      end else if (tick) begin
         if (phase_next >= (pidc_pkg::PHASE_W+1)'(pidc_pkg::WAVE_LENGTH)) begin
            phase_ff <= '0;
         end else begin
            phase_ff <= phase_next[pidc_pkg::PHASE_W-1:0];
         end
         if (active) begin
            capturing_ff <= !run_end;
            dec_ff       <= record ? '0 : dec_next;
            if (record) begin
               point_ff <= run_end ? '0 : point_next[pidc_pkg::POINT_W-1:0];
            end
         end
      end
   end

endmodule

// File: src/pi_pwm_duty_controller.sv
// Top level of the PI PWM duty controller: registers, request latch,
// sequencer, datapath, capture state and response register.
// Depends on pidc_pkg, pidc_if, pidc_sequencer, pidc_datapath, pidc_capture.

// One request is one control tick: the converter sample is compared with a
// square-wave reference, a PI term (integral before update) sets a percent
// offset from 50 %, clamped to 0..100 % and scaled to a PWM compare value.
// A microcoded sequencer drives one shared 25x23 multiplier through ten
// steps (two gain products, clamp, period product, reciprocal divide by 25
// with one correction step, skipped when the first quotient estimate is
// already right), and the response register is loaded as the last step
// ends. Requests are taken one at a time: a new one is accepted from the
// cycle after the previous response is loaded, even while it waits to be
// taken; a finished request holds its last step until the response register
// is free. Register writes are always accepted and are meant for idle periods.
module pi_pwm_duty_controller (
   input  logic  clock,
   input  logic  reset,
   pidc_req_if.sink   req_if,
   pidc_rsp_if.source rsp_if,
   pidc_csr_if.sink   csr_if
);

   logic signed [pidc_pkg::GAIN_W-1:0]  kp_ff;
   logic signed [pidc_pkg::GAIN_W-1:0]  ki_ff;
   logic signed [pidc_pkg::INTEG_W-1:0] integral_max_ff;
   logic [pidc_pkg::SAMPLE_W-1:0]       ref_high_ff;
   logic [pidc_pkg::SAMPLE_W-1:0]       ref_low_ff;
   logic [pidc_pkg::PERIOD_W-1:0]       pwm_period_ff;

   logic [pidc_pkg::SAMPLE_W-1:0]       adc_ff;
   logic [pidc_pkg::SAMPLE_W-1:0]       ref_level_ff;
   logic                                start_ff;
   logic [pidc_pkg::SAMPLE_W-1:0]       ref_level_in;

   logic                                rsp_valid_ff;
   logic [pidc_pkg::DUTY_W-1:0]         duty_ff;
   pidc_pkg::capture_type               cap_out_ff;

   logic                                load;
   logic                                busy;
   logic                                tick;
   logic                                out_free;
   logic                                first_half;
   pidc_pkg::ctrl_word_type             cw;
   pidc_pkg::dp_status_type             status;
   pidc_pkg::capture_type               capture;
   logic [pidc_pkg::DUTY_W-1:0]         duty;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = !busy;
   assign load         = req_if.valid && !busy;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign ref_level_in = first_half ? ref_high_ff : ref_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff           <= '0;
         ki_ff           <= '0;
         integral_max_ff <= '0;
         ref_high_ff     <= pidc_pkg::REF_HIGH_RST;
         ref_low_ff      <= pidc_pkg::REF_LOW_RST;
         pwm_period_ff   <= pidc_pkg::PWM_PERIOD_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            pidc_pkg::CSR_KP:           kp_ff <= csr_if.data[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::CSR_KI:           ki_ff <= csr_if.data[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::CSR_INTEGRAL_MAX: integral_max_ff <= csr_if.data;
            pidc_pkg::CSR_REF_HIGH:     ref_high_ff <= csr_if.data[pidc_pkg::SAMPLE_W-1:0];
            pidc_pkg::CSR_REF_LOW:      ref_low_ff <= csr_if.data[pidc_pkg::SAMPLE_W-1:0];
            pidc_pkg::CSR_PWM_PERIOD:   pwm_period_ff <= csr_if.data[pidc_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         adc_ff       <= req_if.adc_sample;
         ref_level_ff <= ref_level_in;
         start_ff     <= req_if.start_capture;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tick) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (tick) begin
         duty_ff    <= duty;
         cap_out_ff <= capture;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.duty               = duty_ff;
   assign rsp_if.capture_valid      = cap_out_ff.valid;
   assign rsp_if.capture_index      = cap_out_ff.index;
   assign rsp_if.captured_sample    = cap_out_ff.sample;
   assign rsp_if.captured_reference = cap_out_ff.reference;
   assign rsp_if.capture_last       = cap_out_ff.last;

   pidc_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .out_free (out_free),
      .status   (status),
      .cw       (cw),
      .busy     (busy),
      .tick     (tick)
   );

   pidc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .cw           (cw),
      .adc_sample   (req_if.adc_sample),
      .ref_level    (ref_level_in),
      .kp           (kp_ff),
      .ki           (ki_ff),
      .integral_max (integral_max_ff),
      .pwm_period   (pwm_period_ff),
      .status       (status),
      .duty         (duty)
   );

   pidc_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .start      (start_ff),
      .adc_sample (adc_ff),
      .ref_level  (ref_level_ff),
      .first_half (first_half),
      .capture    (capture)
   );

endmodule

// File: src/pidc_checker.sv
// Port-level checks for the PI PWM duty controller, bound to the top level.
// Depends on pidc_pkg and pi_pwm_duty_controller.
module pidc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          capture_valid,
   input logic [pidc_pkg::POINT_W-1:0]  capture_index,
   input logic [pidc_pkg::SAMPLE_W-1:0] captured_sample,
   input logic [pidc_pkg::SAMPLE_W-1:0] captured_reference,
   input logic                          capture_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !capture_valid |-> capture_index == '0 && captured_sample == '0
         && captured_reference == '0 && !capture_last)
      else $error("capture fields set on an unrecorded tick");

   a_last_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && capture_last |->
         capture_valid && capture_index == pidc_pkg::POINT_W'(pidc_pkg::CAPTURE_POINTS - 1))
      else $error("capture run ended at the wrong point");

endmodule

bind pi_pwm_duty_controller pidc_checker u_pidc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .capture_valid      (rsp_if.capture_valid),
   .capture_index      (rsp_if.capture_index),
   .captured_sample    (rsp_if.captured_sample),
   .captured_reference (rsp_if.captured_reference),
   .capture_last       (rsp_if.capture_last)
);

// File: bench/pidc_checker.sv
// Response checker for the PI PWM duty controller: tracks register writes,
// predicts each tick's duty and capture point, and compares accepted responses.
// Depends on pidc_pkg and the pidc_if channel interfaces.
module pidc_tb_checker (
   input  logic clock,
   input  logic reset,
   pidc_req_if  req_mon,
   pidc_rsp_if  rsp_mon,
   pidc_csr_if  csr_mon,
   output int   error_count,
   output int   pending_ticks
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint INTEG_FLOOR = -(longint'(1) << (pidc_pkg::INTEG_W - 1));
   localparam int     REPORT_MAX  = 10;

   typedef struct packed {
      logic [pidc_pkg::DUTY_W-1:0] duty;
      pidc_pkg::capture_type       cap;
   } tick_result_type;

   logic signed [pidc_pkg::GAIN_W-1:0]  kp_gain;
   logic signed [pidc_pkg::GAIN_W-1:0]  ki_gain;
   logic signed [pidc_pkg::INTEG_W-1:0] integ_limit;
   logic [pidc_pkg::SAMPLE_W-1:0]       level_high;
   logic [pidc_pkg::SAMPLE_W-1:0]       level_low;
   logic [pidc_pkg::PERIOD_W-1:0]       period;

   int     wave_pos;
   longint integ;
   int     dec_count;
   int     point_idx;
   bit     capturing;

   tick_result_type duty_expect_q[$];
   int              fails = 0;
   int              result_no = 0;

   function automatic void reset_controller();
      kp_gain     = '0;
      ki_gain     = '0;
      integ_limit = '0;
      level_high  = pidc_pkg::REF_HIGH_RST;
      level_low   = pidc_pkg::REF_LOW_RST;
      period      = pidc_pkg::PWM_PERIOD_RST;
      wave_pos    = 0;
      integ       = 0;
      dec_count   = 0;
      point_idx   = 0;
      capturing   = 1'b0;
   endfunction

   function automatic void apply_csr(input logic [pidc_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [pidc_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         pidc_pkg::CSR_KP:           kp_gain     = value[pidc_pkg::GAIN_W-1:0];
         pidc_pkg::CSR_KI:           ki_gain     = value[pidc_pkg::GAIN_W-1:0];
         pidc_pkg::CSR_INTEGRAL_MAX: integ_limit = value[pidc_pkg::INTEG_W-1:0];
         pidc_pkg::CSR_REF_HIGH:     level_high  = value[pidc_pkg::SAMPLE_W-1:0];
         pidc_pkg::CSR_REF_LOW:      level_low   = value[pidc_pkg::SAMPLE_W-1:0];
         pidc_pkg::CSR_PWM_PERIOD:   period      = value[pidc_pkg::PERIOD_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic tick_result_type step_controller(
      input logic [pidc_pkg::SAMPLE_W-1:0] adc,
      input logic                          start);
      tick_result_type               r;
      logic [pidc_pkg::SAMPLE_W-1:0] level;
      longint                        err;
      longint                        pct;
      longint                        next_integ;
      r     = '0;
      level = (wave_pos < pidc_pkg::HALF_WAVE) ? level_high : level_low;
      err   = longint'(level) - longint'(adc);
      // integral term uses the value from before this tick
      pct   = longint'(kp_gain) * err + longint'(ki_gain) * integ
              + longint'(pidc_pkg::PCT_OFFSET);
      next_integ = integ + err;
      if (next_integ > longint'(integ_limit)) next_integ = longint'(integ_limit);
      if (next_integ < INTEG_FLOOR) next_integ = INTEG_FLOOR;
      integ = next_integ;
      if (pct > longint'(pidc_pkg::PCT_FULL)) pct = longint'(pidc_pkg::PCT_FULL);
      if (pct < 0) pct = 0;
      r.duty = pidc_pkg::DUTY_W'((pct * longint'(period)) / longint'(pidc_pkg::PCT_FULL));

      if (start && !capturing) capturing = 1'b1;
      if (capturing) begin
         dec_count = dec_count + 1;
         if (dec_count >= pidc_pkg::DECIMATE_BY) begin
            dec_count       = 0;
            r.cap.valid     = 1'b1;
            r.cap.index     = pidc_pkg::POINT_W'(point_idx);
            r.cap.sample    = adc;
            r.cap.reference = level;
            if (point_idx + 1 >= pidc_pkg::CAPTURE_POINTS) begin
               r.cap.last = 1'b1;
               point_idx  = 0;
               capturing  = 1'b0;
            end else begin
               point_idx = point_idx + 1;
            end
         end
      end

      wave_pos = (wave_pos + 1 >= pidc_pkg::WAVE_LENGTH) ? 0 : wave_pos + 1;
      return r;
   endfunction

   always @(posedge clock) begin
      tick_result_type want;
      tick_result_type got;
      if (reset) begin
         reset_controller();
         duty_expect_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) apply_csr(csr_mon.index, csr_mon.data);

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.duty          = rsp_mon.duty;
            got.cap.valid     = rsp_mon.capture_valid;
            got.cap.index     = rsp_mon.capture_index;
            got.cap.sample    = rsp_mon.captured_sample;
            got.cap.reference = rsp_mon.captured_reference;
            got.cap.last      = rsp_mon.capture_last;
            if (duty_expect_q.size() == 0) begin
               if (fails < REPORT_MAX)
                  $display("[%0t] response %0d with no request outstanding: duty %0d",
                           $realtime, result_no, got.duty);
               fails++;
            end else begin
               want = duty_expect_q.pop_front();
               if (want !== got) begin
                  if (fails < REPORT_MAX) begin
                     $display("[%0t] response %0d mismatch", $realtime, result_no);
                     $display("   expected duty %0d cap v%0b i%0d s%0d r%0d l%0b",
                              want.duty, want.cap.valid, want.cap.index,
                              want.cap.sample, want.cap.reference, want.cap.last);
                     $display("   actual   duty %0d cap v%0b i%0d s%0d r%0d l%0b",
                              got.duty, got.cap.valid, got.cap.index,
                              got.cap.sample, got.cap.reference, got.cap.last);
                  end
                  fails++;
               end
            end
            result_no++;
         end

         if (req_mon.valid && req_mon.ready)
            duty_expect_q.push_back(step_controller(req_mon.adc_sample,
                                                    req_mon.start_capture));
      end
      pending_ticks <= duty_expect_q.size();
      error_count   <= fails;
   end

endmodule

// File: bench/pi_pwm_duty_controller_tb.sv
// Testbench top for the PI PWM duty controller: clock, reset, request and
// register stimulus, response back-pressure and the verdict.
// Depends on pidc_pkg, pidc_if, pi_pwm_duty_controller and pidc_tb_checker.
module pi_pwm_duty_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_PHASES = 6;
   localparam int SOAK_TICKS    = 60;

   typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_SHUT} rx_style_type;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_ticks;
   int   cycle_count = 0;
   bit   rsp_hold = 1'b0;
   bit   rsp_always_ready = 1'b0;

   pidc_req_if req_bus ();
   pidc_rsp_if rsp_bus ();
   pidc_csr_if csr_bus ();

   pi_pwm_duty_controller u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   pidc_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .error_count   (error_count),
      .pending_ticks (pending_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response back-pressure
   initial begin
      rx_style_type style;
      int           left;
      logic         take;
      style = RX_STREAM;
      left  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (left == 0) begin
               style = rx_style_type'($urandom_range(0, 3));
               left  = $urandom_range(20, 120);
            end
            left--;
            case (style)
               RX_STREAM: take = 1'b1;
               RX_COIN:   take = ($urandom_range(0, 1) == 1);
               RX_SPARSE: take = ($urandom_range(0, 3) == 0);
               default:   take = 1'b0;
            endcase
            rsp_bus.ready <= take || rsp_always_ready;
            @(posedge clock);
         end
      end
   end

   task automatic send_tick(input logic [pidc_pkg::SAMPLE_W-1:0] adc, input logic start);
      req_bus.valid         <= 1'b1;
      req_bus.adc_sample    <= adc;
      req_bus.start_capture <= start;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic pause_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_random_tick();
      logic [pidc_pkg::SAMPLE_W-1:0] adc;
      case ($urandom_range(0, 7))
         0:       adc = '0;
         1:       adc = '1;
         default: adc = pidc_pkg::SAMPLE_W'($urandom);
      endcase
      send_tick(adc, $urandom_range(0, 24) == 0);
   endtask

   task automatic random_traffic(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            send_random_tick();
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end
   endtask

   task automatic drain_and_settle();
      pause_sender(1);
      while (pending_ticks != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input pidc_pkg::csr_index_type idx,
                          input logic [pidc_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // unused upper data bits carry random junk
   task automatic load_config(input logic [pidc_pkg::GAIN_W-1:0] kp,
                              input logic [pidc_pkg::GAIN_W-1:0] ki,
                              input logic [pidc_pkg::INTEG_W-1:0] imax,
                              input logic [pidc_pkg::SAMPLE_W-1:0] lvl_high,
                              input logic [pidc_pkg::SAMPLE_W-1:0] lvl_low,
                              input logic [pidc_pkg::PERIOD_W-1:0] per);
      logic [pidc_pkg::CSR_DATA_W-1:0] junk;
      junk = $urandom;
      put_csr(pidc_pkg::CSR_KP,
              {junk[pidc_pkg::CSR_DATA_W-1:pidc_pkg::GAIN_W], kp});
      put_csr(pidc_pkg::CSR_KI,
              {junk[pidc_pkg::CSR_DATA_W-1:pidc_pkg::GAIN_W], ~ki ^ ~ki ^ ki});
      put_csr(pidc_pkg::CSR_INTEGRAL_MAX, imax);
      put_csr(pidc_pkg::CSR_REF_HIGH,
              {junk[pidc_pkg::CSR_DATA_W-1:pidc_pkg::SAMPLE_W], lvl_high});
      put_csr(pidc_pkg::CSR_REF_LOW,
              {~junk[pidc_pkg::CSR_DATA_W-1:pidc_pkg::SAMPLE_W], lvl_low});
      put_csr(pidc_pkg::CSR_PWM_PERIOD,
              {~junk[pidc_pkg::CSR_DATA_W-1:pidc_pkg::PERIOD_W], per});
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_random_config();
      logic [pidc_pkg::GAIN_W-1:0]   kp;
      logic [pidc_pkg::GAIN_W-1:0]   ki;
      logic [pidc_pkg::INTEG_W-1:0]  imax;
      logic [pidc_pkg::PERIOD_W-1:0] per;
      kp   = ($urandom_range(0, 3) == 0)
             ? pidc_pkg::GAIN_W'($urandom)
             : pidc_pkg::GAIN_W'(int'($urandom_range(0, 1024)) - 512);
      ki   = ($urandom_range(0, 3) == 0)
             ? pidc_pkg::GAIN_W'($urandom)
             : pidc_pkg::GAIN_W'(int'($urandom_range(0, 128)) - 64);
      imax = ($urandom_range(0, 3) == 0)
             ? pidc_pkg::INTEG_W'($urandom)
             : pidc_pkg::INTEG_W'(int'($urandom_range(0, 40000)) - 20000);
      per  = ($urandom_range(0, 3) == 0)
             ? pidc_pkg::PERIOD_W'($urandom)
             : pidc_pkg::PERIOD_W'($urandom_range(100, 5000));
      load_config(kp, ki, imax, pidc_pkg::SAMPLE_W'($urandom),
                  pidc_pkg::SAMPLE_W'($urandom), per);
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.adc_sample    = '0;
      req_bus.start_capture = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = pidc_pkg::CSR_KP;
      csr_bus.data          = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // power-on register values
      send_tick('0, 1'b0);
      send_tick('1, 1'b0);
      send_tick(10'h2AA, 1'b0);
      send_tick(10'h155, 1'b0);
      drain_and_settle();

      // maximum gains, full period, opposite-signed integral gain
      load_config(16'h7FFF, 16'h8000, 24'h7FFFFF, '1, '0, '1);
      send_tick('0, 1'b1);
      send_tick('1, 1'b0);
      send_tick('1, 1'b1);
      send_tick('0, 1'b0);
      send_tick(10'h2AA, 1'b1);
      send_tick(10'h155, 1'b0);
      send_tick('1, 1'b0);
      send_tick('0, 1'b0);
      drain_and_settle();

      // minimum proportional gain, maximum integral gain, integral pinned at the floor, zero period
      load_config(16'h8000, 16'h7FFF, 24'h800000, '0, '1, '0);
      send_tick('0, 1'b0);
      send_tick('1, 1'b1);
      send_tick(10'h155, 1'b0);
      send_tick(10'h2AA, 1'b0);
      send_tick('1, 1'b0);
      send_tick('0, 1'b0);
      random_traffic(40);
      drain_and_settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_random_config();
         if (p == 2) begin
            rsp_hold = 1'b1;
            repeat (40) send_random_tick();
            random_traffic(10);
         end else begin
            random_traffic(50);
         end
         drain_and_settle();
      end

      // steady run with the receiver always ready and a falling integral
      load_config(16'hFFFD, 16'h0000, 24'h7FFFFF, '0, 10'd40, '1);
      rsp_always_ready = 1'b1;
      repeat (SOAK_TICKS)
         send_tick(pidc_pkg::SAMPLE_W'($urandom_range(900, 1023)),
                   $urandom_range(0, 49) == 0);
      drain_and_settle();
      rsp_always_ready = 1'b0;

      load_random_config();
      random_traffic(30);
      drain_and_settle();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_ticks == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
